### rtl/core/twtoa_pkg.sv
`timescale 1ns / 1ps

package twtoa_pkg;

  localparam int unsigned TOA_W      = 54;
  localparam int unsigned TOT_W      = 16;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned TIME_W     = 64;
  localparam int unsigned OUT_DATA_W = 2 * TIME_W;

  localparam int unsigned A_W        = 48;
  localparam int unsigned B_W        = 32;
  localparam int unsigned M_W        = 32;
  localparam int unsigned ANCHOR_W   = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  localparam int unsigned NUM_W      = A_W + 8;
  localparam int unsigned DEN_W      = 33;
  localparam int unsigned DSGN_W     = DEN_W + 1;
  localparam int unsigned DELTA_W    = NUM_W + 2;
  localparam int unsigned DIFF_W     = ANCHOR_W + 2;
  localparam int unsigned PROD_W     = M_W + DIFF_W;

  localparam int unsigned DIV_STEPS  = 2;
  localparam int unsigned DIV_CYCLES = NUM_W / DIV_STEPS;
  localparam int unsigned CNT_W      = $clog2(DIV_CYCLES);

  localparam logic [CFG_IDX_W-1:0] CFG_MODEL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_M = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR = 3'd4;

  localparam logic MODEL_INVERSE = 1'b0;
  localparam logic MODEL_LINEAR  = 1'b1;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] quo;
  } div_st_t;

  function automatic div_st_t div_step(input div_st_t cur, input logic [DEN_W-1:0] den);
    logic [DEN_W:0] rem_sh;
    logic [DEN_W:0] diff;
    div_st_t        nxt;
    rem_sh = {cur.rem, cur.quo[NUM_W-1]};
    diff   = rem_sh - {1'b0, den};
    if (rem_sh >= {1'b0, den}) begin
      nxt.rem = diff[DEN_W-1:0];
      nxt.quo = {cur.quo[NUM_W-2:0], 1'b1};
    end else begin
      nxt.rem = rem_sh[DEN_W-1:0];
      nxt.quo = {cur.quo[NUM_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

### rtl/core/timewalk_toa_correct_min.sv
`timescale 1ns / 1ps
// Inverse model: two 56-bit quotients from one shared restoring divider, 2 quotient bits per
// cycle; the linear model and a zero denominator do not use the divider.
// One hit at a time: s_axis_tready high only while idle, so a new hit waits until the
// previous result is registered; the output register holds a result until taken.
// Reset (rst_ni low, asynchronous): control and configuration registers zero, inverse
// model, cluster minimum empty.

module timewalk_toa_correct_min (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [twtoa_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [twtoa_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // hit_toa [53:0], hit_tot [69:54], zero fill [71:70]
  input  logic [twtoa_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  input  logic                                  s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // corrected_toa [63:0], cluster_earliest [127:64]
  output logic [twtoa_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                                  m_axis_tlast,
  // div_fault [0]
  output logic                                  m_axis_tuser
);

  import twtoa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_LIN,
    ST_DIV1,
    ST_DIV2,
    ST_FIN
  } state_e;

  state_e                     state_q;
  logic [CNT_W-1:0]           cnt_q;
  logic                       m_valid_q;
  logic signed [TIME_W-1:0]   run_min_q;
  logic                       first_pending_q;

  logic                       model_q;
  logic [A_W-1:0]             coef_a_q;
  logic [B_W-1:0]             coef_b_q;
  logic [M_W-1:0]             coef_m_q;
  logic [ANCHOR_W-1:0]        anchor_q;

  logic [TOA_W-1:0]           toa_q;
  logic [TOT_W-1:0]           tot_q;
  logic                       last_q;
  logic                       fault_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [DELTA_W-1:0]  delta_q;
  div_st_t                    div_q;
  logic [DEN_W-1:0]           den_q;
  logic                       neg_q;

  logic [TIME_W-1:0]          out_toa_q;
  logic [TIME_W-1:0]          out_earliest_q;
  logic                       out_last_q;
  logic                       out_fault_q;

  logic [NUM_W-1:0]           num_s;
  logic [NUM_W-1:0]           num_neg;
  logic [NUM_W-1:0]           num_mag;
  logic [DSGN_W-1:0]          b_ext;
  logic [DSGN_W-1:0]          d1;
  logic [DSGN_W-1:0]          d2;
  logic [DSGN_W-1:0]          d1_neg;
  logic [DSGN_W-1:0]          d2_neg;
  logic [DEN_W-1:0]           d1_mag;
  logic [DEN_W-1:0]           d2_mag;
  logic                       den_zero;
  logic signed [DIFF_W-1:0]   diff_d;
  logic signed [PROD_W-1:0]   prod_d;
  logic signed [PROD_W-1:0]   prod_adj;
  div_st_t                    st1;
  div_st_t                    st2;
  logic signed [DELTA_W-1:0]  qmag_ext;
  logic signed [TIME_W-1:0]   corrected_d;
  logic signed [TIME_W-1:0]   min_d;
  logic                       take_d;
  logic                       in_fire;
  logic                       fin_go;
  logic                       div_done;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign fin_go        = (state_q == ST_FIN) && (!m_valid_q || m_axis_tready);
  assign div_done      = (cnt_q == CNT_W'(DIV_CYCLES - 1));

  assign num_s    = {coef_a_q, 8'h00};
  assign num_neg  = ~num_s + NUM_W'(1);
  assign num_mag  = num_s[NUM_W-1] ? num_neg : num_s;
  assign b_ext    = {{(DSGN_W - B_W){coef_b_q[B_W-1]}}, coef_b_q};
  assign d1       = {{(DSGN_W - TOT_W - 16){1'b0}}, tot_q, 16'h0000} + b_ext;
  assign d2       = {{(DSGN_W - ANCHOR_W - 8){1'b0}}, anchor_q, 8'h00} + b_ext;
  assign d1_neg   = ~d1 + DSGN_W'(1);
  assign d2_neg   = ~d2 + DSGN_W'(1);
  assign d1_mag   = d1[DSGN_W-1] ? d1_neg[DEN_W-1:0] : d1[DEN_W-1:0];
  assign d2_mag   = d2[DSGN_W-1] ? d2_neg[DEN_W-1:0] : d2[DEN_W-1:0];
  assign den_zero = (d1 == '0) || (d2 == '0);

  assign diff_d   = $signed({2'b00, tot_q, 8'h00}) - $signed({2'b00, anchor_q});
  assign prod_d   = $signed(coef_m_q) * diff_d;
  assign prod_adj = prod_q + (prod_q[PROD_W-1] ? PROD_W'(16'hFFFF) : PROD_W'(0));

  assign st1      = div_step(div_q, den_q);
  assign st2      = div_step(st1, den_q);
  assign qmag_ext = $signed({{(DELTA_W - NUM_W){1'b0}}, st2.quo});

  assign corrected_d = $signed({{(TIME_W - TOA_W - 8){1'b0}}, toa_q, 8'h00})
                     - $signed({{(TIME_W - DELTA_W){delta_q[DELTA_W-1]}}, delta_q});
  assign take_d      = first_pending_q || (corrected_d < run_min_q);
  assign min_d       = take_d ? corrected_d : run_min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      cnt_q           <= '0;
      m_valid_q       <= 1'b0;
      run_min_q       <= '0;
      first_pending_q <= 1'b1;
      model_q         <= MODEL_INVERSE;
      coef_a_q        <= '0;
      coef_b_q        <= '0;
      coef_m_q        <= '0;
      anchor_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_MODEL:  model_q  <= cfg_data_i[0];
          CFG_COEF_A: coef_a_q <= cfg_data_i[A_W-1:0];
          CFG_COEF_B: coef_b_q <= cfg_data_i[B_W-1:0];
          CFG_COEF_M: coef_m_q <= cfg_data_i[M_W-1:0];
          CFG_ANCHOR: anchor_q <= cfg_data_i[ANCHOR_W-1:0];
          default: ;
        endcase
      end
      if (m_valid_q && m_axis_tready && !fin_go) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          cnt_q <= '0;
          if (model_q == MODEL_LINEAR) begin
            state_q <= ST_LIN;
          end else if (den_zero) begin
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_DIV1;
          end
        end
        ST_LIN: begin
          state_q <= ST_FIN;
        end
        ST_DIV1: begin
          if (div_done) begin
            cnt_q   <= '0;
            state_q <= ST_DIV2;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_DIV2: begin
          if (div_done) begin
            state_q <= ST_FIN;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
            if (last_q) begin
              run_min_q       <= '0;
              first_pending_q <= 1'b1;
            end else begin
              run_min_q       <= min_d;
              first_pending_q <= 1'b0;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      toa_q  <= s_axis_tdata[TOA_W-1:0];
      tot_q  <= s_axis_tdata[TOA_W +: TOT_W];
      last_q <= s_axis_tlast;
    end
    if (state_q == ST_PREP) begin
      prod_q    <= prod_d;
      fault_q   <= (model_q == MODEL_INVERSE) && den_zero;
      delta_q   <= '0;
      div_q.rem <= '0;
      div_q.quo <= num_mag;
      den_q     <= d1_mag;
      neg_q     <= num_s[NUM_W-1] ^ d1[DSGN_W-1];
    end
    if (state_q == ST_LIN) begin
      delta_q <= prod_adj >>> 16;
    end
    if (state_q == ST_DIV1) begin
      if (div_done) begin
        delta_q   <= neg_q ? -qmag_ext : qmag_ext;
        div_q.rem <= '0;
        div_q.quo <= num_mag;
        den_q     <= d2_mag;
        neg_q     <= num_s[NUM_W-1] ^ d2[DSGN_W-1];
      end else begin
        div_q <= st2;
      end
    end
    if (state_q == ST_DIV2) begin
      if (div_done) begin
        delta_q <= neg_q ? (delta_q + qmag_ext) : (delta_q - qmag_ext);
      end else begin
        div_q <= st2;
      end
    end
    if (fin_go) begin
      out_toa_q      <= corrected_d;
      out_earliest_q <= last_q ? min_d : '0;
      out_last_q     <= last_q;
      out_fault_q    <= fault_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {out_earliest_q, out_toa_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_fault_q;

endmodule

### rtl/core/twtoa_checker.sv
`timescale 1ns / 1ps

module twtoa_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  s_axis_tvalid,
  input logic                                  s_axis_tready,
  input logic                                  m_axis_tvalid,
  input logic                                  m_axis_tready,
  input logic [twtoa_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  input logic                                  m_axis_tlast
);

  import twtoa_pkg::*;

  // hold result while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // drop cluster minimum on hits that do not close a cluster
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[OUT_DATA_W-1:TIME_W] == '0)
    else $error("cluster_earliest nonzero on open cluster");

  // one hit at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

  // no result in the cycle right after a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("result too early");

endmodule

bind timewalk_toa_correct_min twtoa_checker u_twtoa_checker (.*);
